// File: src/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
// No dependencies; used by every module of the block.
package kmd_pkg;

  localparam int unsigned KEY_SLOTS_DEF = 256;
  localparam int unsigned POS_W         = 8;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned LIMIT_W       = 6;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd5;
  localparam logic               MODE_RST  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_HELD  = 2'd1,
    KIND_MAKE  = 2'd2,
    KIND_BREAK = 2'd3
  } kmd_kind_e;

  // Per-key record held in the key store
  typedef struct packed {
    logic              prev;
    logic [CNT_W-1:0]  count;
    logic [CODE_W-1:0] saved;
  } kmd_rec_t;

  // Value of a record that was never written (saved code is don't care)
  localparam kmd_rec_t REC_RST = '{prev: 1'b0, count: {CNT_W{1'b1}}, saved: '0};

endpackage

// File: src/kmd_key_store.sv
// Per-key record memory with reset-cleared valid bits and a write bypass.
// Depends on kmd_pkg for the record type and its reset value.
module kmd_key_store #(
  parameter int unsigned KEY_SLOTS = kmd_pkg::KEY_SLOTS_DEF,
  localparam int unsigned AW = $clog2(KEY_SLOTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output kmd_pkg::kmd_rec_t rd_rec_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  kmd_pkg::kmd_rec_t wr_rec_i
);

  kmd_pkg::kmd_rec_t mem [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] valid_q;

  kmd_pkg::kmd_rec_t rd_data_q;
  logic              rd_valid_q;
  logic              fwd_q;
  kmd_pkg::kmd_rec_t fwd_rec_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      fwd_rec_q <= wr_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        // a write in the same cycle to the same key is not yet in the array
        fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_rec_o = fwd_rec_q;
    end else if (rd_valid_q) begin
      rd_rec_o = rd_data_q;
    end else begin
      rd_rec_o = kmd_pkg::REC_RST;
    end
  end

endmodule

// File: src/kmd_update.sv
// Debounce update for one key sample: new record and the event it gives.
// Depends on kmd_pkg for the record type and event kinds.
module kmd_update (
  input  kmd_pkg::kmd_rec_t              rec_i,
  input  logic                           level_i,
  input  logic [kmd_pkg::CODE_W-1:0]     code_i,
  input  logic                           eligible_i,
  input  logic [kmd_pkg::LIMIT_W-1:0]    limit_i,
  input  logic                           report_mode_i,
  output kmd_pkg::kmd_rec_t              rec_o,
  output kmd_pkg::kmd_kind_e             kind_o,
  output logic [kmd_pkg::CODE_W-1:0]     code_o
);

  logic [kmd_pkg::CNT_W-1:0] lim_ext;
  logic [kmd_pkg::CNT_W-1:0] cnt_mb;
  logic                      rpt_ge;
  logic                      mb_fire;

  assign lim_ext = {2'b00, limit_i};
  assign rpt_ge  = $signed(rec_i.count) >= $signed(lim_ext);
  // a level change restarts the make/break counter
  assign cnt_mb  = (rec_i.prev != level_i) ? '0 : rec_i.count;
  assign mb_fire = !cnt_mb[kmd_pkg::CNT_W-1] && ($signed(cnt_mb) >= $signed(lim_ext));

  always_comb begin
    rec_o      = rec_i;
    rec_o.prev = level_i;
    kind_o     = kmd_pkg::KIND_NONE;
    code_o     = '0;
    if (eligible_i) begin
      if (report_mode_i) begin
        if (rpt_ge) begin
          kind_o = kmd_pkg::KIND_HELD;
          code_o = code_i;
        end
        if (level_i) begin
          rec_o.count = rpt_ge ? {1'b0, limit_i, 1'b0} : rec_i.count + 1'b1;
        end else begin
          rec_o.count = rpt_ge ? rec_i.count - 1'b1 : '0;
        end
      end else begin
        rec_o.count = cnt_mb;
        if (!cnt_mb[kmd_pkg::CNT_W-1]) begin
          rec_o.count = cnt_mb + 1'b1;
        end
        if (mb_fire) begin
          rec_o.count = '1;
          if (level_i) begin
            kind_o      = kmd_pkg::KIND_MAKE;
            code_o      = code_i;
            rec_o.saved = code_i;
          end else begin
            kind_o = kmd_pkg::KIND_BREAK;
            code_o = rec_i.saved;
          end
        end
      end
    end
  end

endmodule

// File: src/key_matrix_debouncer.sv
// Top level of the key matrix debouncer: stream ports, config registers,
// the sample stage and the result register. Uses kmd_pkg, kmd_key_store, kmd_update.
//
//  Channel  | Direction | Fields
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata: key_position, level_now, key_code; tuser: eligible
//  m_axis   | out       | tdata: event_code; tuser: event_kind
//  cfg      | in        | index 0 debounce_limit, index 1 report_mode
//
// One word per cycle in steady state while m_axis does not stall; each word
// passes the key store read, registered with the sample stage, and then the
// update into the result register. The key store is a single-read single-write
// memory; back-to-back words on the same key are served by a write bypass.
// Reset clears the valid bits of all keys at once, so no clearing pass is
// needed. A stalled result holds the sample stage, which then holds s_axis.
module key_matrix_debouncer #(
  parameter int unsigned KEY_SLOTS = kmd_pkg::KEY_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [23:0]                        s_axis_tdata,  // key_position[7:0], level_now[8],
                                                            // key_code[16:9], zero[23:17]
  input  logic                               s_axis_tuser,  // eligible[0]
  // event stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // event_code[7:0]
  output logic [1:0]                         m_axis_tuser,  // event_kind[1:0]
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(KEY_SLOTS);

  // configuration registers
  logic [kmd_pkg::LIMIT_W-1:0] limit_q;
  logic                        mode_q;

  // unpacked input word
  logic [kmd_pkg::POS_W-1:0]  in_pos;
  logic                       in_level;
  logic [kmd_pkg::CODE_W-1:0] in_code;
  logic                       in_accept;
  logic                       in_range;

  // sample stage
  logic                       s1_valid_q;
  logic                       s1_range_q;
  logic [AW-1:0]              s1_addr_q;
  logic                       s1_level_q;
  logic [kmd_pkg::CODE_W-1:0] s1_code_q;
  logic                       s1_elig_q;
  logic                       s1_advance;

  // result register
  logic                       out_valid_q;
  kmd_pkg::kmd_kind_e         out_kind_q;
  logic [kmd_pkg::CODE_W-1:0] out_code_q;

  kmd_pkg::kmd_rec_t          rec_rd;
  kmd_pkg::kmd_rec_t          rec_wr;
  kmd_pkg::kmd_kind_e         upd_kind;
  logic [kmd_pkg::CODE_W-1:0] upd_code;
  logic                       wr_en;

  assign in_pos   = s_axis_tdata[7:0];
  assign in_level = s_axis_tdata[8];
  assign in_code  = s_axis_tdata[16:9];

  // positions past the last slot are ignored and give no event
  assign in_range = ({1'b0, in_pos} < 9'(KEY_SLOTS));

  // advance the sample stage when the result register is free or drains
  assign s1_advance    = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_advance && s1_range_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= kmd_pkg::LIMIT_RST;
      mode_q  <= kmd_pkg::MODE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        kmd_pkg::CFG_LIMIT: limit_q <= cfg_data_i[kmd_pkg::LIMIT_W-1:0];
        kmd_pkg::CFG_MODE:  mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  kmd_key_store #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept),
    .rd_addr_i(in_pos[AW-1:0]),
    .rd_rec_o (rec_rd),
    .wr_en_i  (wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_rec_i (rec_wr)
  );

  kmd_update u_update (
    .rec_i        (rec_rd),
    .level_i      (s1_level_q),
    .code_i       (s1_code_q),
    .eligible_i   (s1_elig_q),
    .limit_i      (limit_q),
    .report_mode_i(mode_q),
    .rec_o        (rec_wr),
    .kind_o       (upd_kind),
    .code_o       (upd_code)
  );

  // sample stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // sample stage payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_range_q <= in_range;
      s1_addr_q  <= in_pos[AW-1:0];
      s1_level_q <= in_level;
      s1_code_q  <= in_code;
      s1_elig_q  <= s_axis_tuser;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_kind_q <= s1_range_q ? upd_kind : kmd_pkg::KIND_NONE;
      out_code_q <= s1_range_q ? upd_code : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

// File: bench/tb_key_matrix_debouncer.sv
`timescale 1ns / 1ps
// Self-checking bench for key_matrix_debouncer: random stalls on both streams,
// per-key debounce prediction, in-order event check. Depends on kmd_pkg and the RTL.
module tb_key_matrix_debouncer;

  localparam int CYCLE_LIMIT = 200000;

  // One scan sample as the sender sees it
  typedef struct {
    logic [7:0] pos;
    logic       level;
    logic [7:0] code;
    logic       elig;
  } scan_sample_t;

  typedef struct {
    kmd_pkg::kmd_kind_e kind;
    logic [7:0]         code;
  } key_event_t;

  // Per-key debounce predictor plus the queue of events it still owes.
  class key_event_board;
    logic       prev_level [256];
    logic [7:0] count      [256];
    logic [7:0] saved      [256];
    bit         saved_ok   [256];
    logic [5:0] limit;
    logic       report;
    key_event_t owed [$];
    int         mismatches;

    function new();
      limit      = kmd_pkg::LIMIT_RST;
      report     = kmd_pkg::MODE_RST;
      mismatches = 0;
      foreach (count[k]) begin
        prev_level[k] = 1'b0;
        count[k]      = 8'hFF;
        saved[k]      = 8'h00;
        saved_ok[k]   = 1'b0;
      end
    endfunction

    function void set_config(logic [5:0] lim, logic mode);
      limit  = lim;
      report = mode;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // True when this sample would give a break on a key that never made.
    function bit breaks_unknown_code(scan_sample_t s);
      logic [7:0] c;
      if (report || !s.elig || s.level || saved_ok[s.pos]) return 1'b0;
      c = (prev_level[s.pos] != s.level) ? 8'h00 : count[s.pos];
      return int'($signed(c)) >= int'(limit);
    endfunction

    // Every 8-bit position lies inside the 256-key store.
    function void note_sample(scan_sample_t s);
      key_event_t ev;
      logic [7:0] c;
      logic       was;
      int         cv;
      ev.kind = kmd_pkg::KIND_NONE;
      ev.code = 8'h00;
      was = prev_level[s.pos];
      prev_level[s.pos] = s.level;
      if (s.elig) begin
        c  = count[s.pos];
        cv = int'($signed(c));
        if (report) begin
          if (cv >= int'(limit)) begin
            ev.kind = kmd_pkg::KIND_HELD;
            ev.code = s.code;
            c = s.level ? {1'b0, limit, 1'b0} : c - 8'd1;
          end else begin
            c = s.level ? c + 8'd1 : 8'h00;
          end
        end else begin
          if (was != s.level) c = 8'h00;
          cv = int'($signed(c));
          if (cv >= 0) begin
            c = c + 8'd1;
            if (cv >= int'(limit)) begin
              if (s.level) begin
                ev.kind = kmd_pkg::KIND_MAKE;
                ev.code = s.code;
                saved[s.pos]    = s.code;
                saved_ok[s.pos] = 1'b1;
              end else begin
                ev.kind = kmd_pkg::KIND_BREAK;
                ev.code = saved[s.pos];
              end
              c = 8'hFF;
            end
          end
        end
        count[s.pos] = c;
      end
      owed.push_back(ev);
    endfunction

    function void check_event(logic [1:0] kind, logic [7:0] code);
      key_event_t ev;
      if (owed.size() == 0) begin
        $display("%0t: event with none owed: kind %0d code %02h", $time, kind, code);
        mismatches++;
        return;
      end
      ev = owed.pop_front();
      if (kind !== ev.kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $time, ev.kind, kind);
        mismatches++;
      end
      if (code !== ev.code) begin
        $display("%0t: event_code expected %02h actual %02h", $time, ev.code, code);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [23:0]                    s_axis_tdata  = '0;   // key_position[7:0], level_now[8],
                                                        // key_code[16:9], zero[23:17]
  logic                           s_axis_tuser  = 1'b0; // eligible[0]
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;         // event_code[7:0]
  logic [1:0]                     m_axis_tuser;         // event_kind[1:0]
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [kmd_pkg::CFG_IDX_W-1:0]  cfg_index_i   = kmd_pkg::CFG_LIMIT;
  logic [kmd_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  key_event_board board;
  bit             calm   = 1'b0;  // set: neither side idles
  int             cycles = 0;

  key_matrix_debouncer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run; a hang anywhere ends up here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Event side: stall at random, check every accepted word against the oldest owed event.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_event(m_axis_tuser, m_axis_tdata);
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  function automatic scan_sample_t mk(logic [7:0] pos, logic level, logic [7:0] code,
                                      logic elig);
    scan_sample_t s;
    s.pos   = pos;
    s.level = level;
    s.code  = code;
    s.elig  = elig;
    return s;
  endfunction

  // Offer one sample word, optionally after a random gap; leave tvalid high on return.
  task automatic push_sample(scan_sample_t s);
    int gap;
    gap = 0;
    // never ask for a break on a key whose make code was never captured
    if (board.breaks_unknown_code(s)) s.elig = 1'b0;
    if (!calm) while ($urandom_range(0, 99) < 35) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, s.code, s.level, s.pos};
    s_axis_tuser  <= s.elig;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(s);
  endtask

  // Drop tvalid and hold until every owed event has come back.
  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back; only call with the block drained.
  task automatic write_config(logic [5:0] lim, logic mode);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= kmd_pkg::CFG_LIMIT;
    cfg_data_i  <= {2'b0, lim};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= kmd_pkg::CFG_MODE;
    cfg_data_i  <= {7'b0, mode};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_config(lim, mode);
  endtask

  // Random phase: a few keys held in runs with occasional bounces, plus noise words.
  task automatic run_phase(logic [5:0] lim, logic mode, int n, bit quiet);
    logic [7:0]   pool_key   [4];
    logic [7:0]   pool_code  [4];
    logic         pool_level [4];
    int           npool;
    int           k;
    scan_sample_t s;
    drain_events();
    write_config(lim, mode);
    calm  = quiet;
    npool = (lim > 31) ? 2 : 4;
    for (int j = 0; j < 4; j++) begin
      pool_key[j]   = 8'($urandom_range(0, 255));
      pool_code[j]  = 8'($urandom_range(0, 255));
      pool_level[j] = 1'($urandom_range(0, 1));
    end
    for (int i = 0; i < n; i++) begin
      // hold the sender once mid-phase until the pipe is empty
      if (i == n / 2 && !quiet) drain_events();
      if ($urandom_range(0, 9) == 0) begin
        s = mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        k = int'($urandom_range(0, npool - 1));
        if ($urandom_range(0, int'(lim) + 16) == 0) pool_level[k] = ~pool_level[k];
        if ($urandom_range(0, 15) == 0) pool_code[k] = 8'($urandom_range(0, 255));
        s = mk(pool_key[k], pool_level[k], pool_code[k], $urandom_range(0, 19) != 0);
        // short bounce against the held level, only where the limit is small
        if (lim < 16 && $urandom_range(0, 11) == 0) s.level = ~s.level;
      end
      push_sample(s);
    end
    calm = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, report mode: reach the limit, then decay after release.
    repeat (7) push_sample(mk(8'd0, 1'b1, 8'h00, 1'b1));
    repeat (2) push_sample(mk(8'd0, 1'b0, 8'h00, 1'b1));
    // ineligible key: level is tracked, counter untouched, no event
    push_sample(mk(8'd255, 1'b1, 8'hFF, 1'b0));

    // Make/break with zero limit: make, break with the saved code, then quiet.
    drain_events();
    write_config(6'd0, 1'b0);
    push_sample(mk(8'd1, 1'b1, 8'hA5, 1'b1));
    push_sample(mk(8'd1, 1'b0, 8'h5A, 1'b1));
    push_sample(mk(8'd1, 1'b0, 8'h5A, 1'b1));
    // level unchanged since the ineligible sample: counter idle at minus one
    push_sample(mk(8'd255, 1'b1, 8'hFF, 1'b1));
    push_sample(mk(8'd255, 1'b0, 8'h00, 1'b0));
    push_sample(mk(8'd255, 1'b1, 8'hFF, 1'b1));
    push_sample(mk(8'd255, 1'b0, 8'h00, 1'b1));

    run_phase(6'd0,  1'b1, 180, 1'b0);
    run_phase(6'd63, 1'b1, 220, 1'b0);
    run_phase(6'd3,  1'b1, 180, 1'b1);
    run_phase(6'd0,  1'b0, 180, 1'b0);
    run_phase(6'd63, 1'b0, 260, 1'b0);
    run_phase(6'($urandom_range(1, 10)), 1'b0, 230, 1'b0);

    drain_events();
    // let the two-stage pipe settle so a stray word still gets caught
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
